>>> rtl/core/ile_pkg.sv
// ile_pkg: shared types, codes and sizes for the indexed list engine
// depends on nothing; imported by ile_cell, ile_ctrl and indexed_list_engine

package ile_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int POS_W   = 5;
	localparam int COUNT_W = 5;
	localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_INS_AT   = 3'd2,
		CMD_DEL_HEAD = 3'd3,
		CMD_DEL_TAIL = 3'd4,
		CMD_DEL_AT   = 3'd5,
		CMD_READ     = 3'd6
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BAD   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_UP   = 2'd1,
		CELL_DOWN = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic [2:0]              command;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]        position;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [COUNT_W-1:0]      count;
		logic [1:0]              status;
	} rsp_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t                op;
		logic [IDX_W-1:0]        pos;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

	// decode result handed back to the top level
	typedef struct packed {
		logic             read_hit;
		logic [CNT_W-1:0] count_next;
		status_t          status;
	} ctrl_res_t;

endpackage

>>> rtl/core/indexed_list_engine.sv
// indexed_list_engine: ordered list held in a chain of shifting cells
// depends on ile_pkg, ile_cell, ile_ctrl
//
//  channel | signals                     | item
//  --------+-----------------------------+-------------------------------
//  command | cmd_valid, cmd_ready, cmd   | command, value, position
//  result  | rsp_valid, rsp_ready, rsp   | read_value, count, status
//
// one command per cycle: on an insert or delete, cells from the position up
// load a neighbor or the new value when the item is accepted; the result is in
// the output register the next cycle. a new command is taken while the result
// register is empty or being emptied, so rsp_ready stalls hold off cmd_ready.
// reset clears the count and the output valid; cell contents are not reset.

module indexed_list_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ile_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ile_pkg::rsp_t  rsp
);
	import ile_pkg::*;

	logic                     fire;
	cell_ctl_t                ctl;
	ctrl_res_t                res;
	logic signed [DATA_W-1:0] cell_val [DEPTH];
	logic signed [DATA_W-1:0] rd_data;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign fire      = cmd_valid && cmd_ready;

	ile_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd),
		.ctl    (ctl),
		.res    (res)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] prev_val;
		logic signed [DATA_W-1:0] next_val;

		if (i == 0) begin : g_head
			assign prev_val = cell_val[i];
		end else begin : g_mid_prev
			assign prev_val = cell_val[i-1];
		end

		// the last cell only shifts down past the tail, so its value is a don't care
		if (i == DEPTH - 1) begin : g_tail
			assign next_val = cell_val[i];
		end else begin : g_mid_next
			assign next_val = cell_val[i+1];
		end

		ile_cell u_cell (
			.clk   (clk),
			.fire  (fire),
			.ctl   (ctl),
			.idx   (IDX_W'(i)),
			.prev  (prev_val),
			.next  (next_val),
			.val_q (cell_val[i])
		);
	end

	assign rd_data = cell_val[IDX_W'(cmd.position)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.read_value <= res.read_hit ? rd_data : '0;
			rsp_q.count      <= COUNT_W'(res.count_next);
			rsp_q.status     <= res.status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> rtl/core/ile_cell.sv
// ile_cell: one storage cell of the list chain, shifts up, down or holds
// depends on ile_pkg

module ile_cell (
	input  logic                          clk,
	input  logic                          fire,
	input  ile_pkg::cell_ctl_t            ctl,
	input  logic [ile_pkg::IDX_W-1:0]     idx,
	input  logic signed [ile_pkg::DATA_W-1:0] prev,
	input  logic signed [ile_pkg::DATA_W-1:0] next,
	output logic signed [ile_pkg::DATA_W-1:0] val_q
);
	import ile_pkg::*;

	always_ff @(posedge clk) begin
		if (fire) begin
			unique case (ctl.op)
				CELL_UP: begin
					if (idx == ctl.pos) begin
						val_q <= ctl.value;
					end else if (idx > ctl.pos) begin
						val_q <= prev;
					end
				end
				CELL_DOWN: begin
					if (idx >= ctl.pos) begin
						val_q <= next;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/core/ile_ctrl.sv
// ile_ctrl: command decode, bound checks and the entry count register
// depends on ile_pkg

module ile_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  ile_pkg::cmd_t         cmd,
	output ile_pkg::cell_ctl_t    ctl,
	output ile_pkg::ctrl_res_t    res
);
	import ile_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic             full;
	logic             empty;

	assign pos_x = CMP_W'(cmd.position);
	assign cnt_x = CMP_W'(count_q);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		ctl.op         = CELL_HOLD;
		ctl.pos        = '0;
		ctl.value      = cmd.value;
		res.read_hit   = 1'b0;
		res.count_next = count_q;
		res.status     = ST_OK;
		unique case (cmd.command)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
				if (full) begin
					res.status = ST_FULL;
				end else if (cmd.command == CMD_INS_AT && pos_x > cnt_x) begin
					res.status = ST_BAD;
				end else begin
					ctl.op = CELL_UP;
					if (cmd.command == CMD_INS_HEAD) begin
						ctl.pos = '0;
					end else if (cmd.command == CMD_INS_TAIL) begin
						ctl.pos = IDX_W'(count_q);
					end else begin
						ctl.pos = IDX_W'(cmd.position);
					end
					res.count_next = count_q + CNT_W'(1);
				end
			end
			CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else if (cmd.command == CMD_DEL_AT && pos_x >= cnt_x) begin
					res.status = ST_BAD;
				end else begin
					ctl.op = CELL_DOWN;
					if (cmd.command == CMD_DEL_HEAD) begin
						ctl.pos = '0;
					end else if (cmd.command == CMD_DEL_TAIL) begin
						ctl.pos = IDX_W'(count_q - CNT_W'(1));
					end else begin
						ctl.pos = IDX_W'(cmd.position);
					end
					res.count_next = count_q - CNT_W'(1);
				end
			end
			CMD_READ: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					res.status = ST_BAD;
				end else begin
					res.read_hit = 1'b1;
				end
			end
			// unused code: no change, status ok
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= res.count_next;
		end
	end

endmodule

>>> tb/sv/testbench.sv
// testbench: self-checking bench for indexed_list_engine with a list tracker that
// predicts each response, directed corner items, then biased random phases
// depends on ile_pkg and the indexed_list_engine rtl

module testbench;
	import ile_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int STALL_LIMIT     = 1000;
	localparam int ITEMS_PER_PHASE = 370;

	class list_tracker;
		logic signed [DATA_W-1:0] cells[$];
		rsp_t expected_rsps[$];
		int errors;
		int commands;
		int results;
		int status_seen[4];

		function rsp_t predict_command(cmd_t c);
			rsp_t r;
			r = '0;
			r.status = ST_OK;
			case (c.command)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
				// full check wins over the position check
				if (cells.size() >= DEPTH)
					r.status = ST_FULL;
				else if (c.command == CMD_INS_HEAD)
					cells.push_front(c.value);
				else if (c.command == CMD_INS_TAIL)
					cells.push_back(c.value);
				else if (c.position > cells.size())
					r.status = ST_BAD;
				else
					cells.insert(c.position, c.value);
			end
			CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT: begin
				if (cells.size() == 0)
					r.status = ST_EMPTY;
				else if (c.command == CMD_DEL_HEAD)
					void'(cells.pop_front());
				else if (c.command == CMD_DEL_TAIL)
					void'(cells.pop_back());
				else if (c.position >= cells.size())
					r.status = ST_BAD;
				else
					cells.delete(c.position);
			end
			CMD_READ: begin
				if (cells.size() == 0)
					r.status = ST_EMPTY;
				else if (c.position >= cells.size())
					r.status = ST_BAD;
				else
					r.read_value = cells[c.position];
			end
			default: ;
			endcase
			r.count = COUNT_W'(cells.size());
			return r;
		endfunction

		task report(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		endtask

		function void take_command(cmd_t c);
			expected_rsps.push_back(predict_command(c));
			commands++;
		endfunction

		task check_response(rsp_t got);
			rsp_t want;
			results++;
			status_seen[got.status]++;
			if (expected_rsps.size() == 0) begin
				report("unexpected result", '0, got.read_value);
			end else begin
				want = expected_rsps.pop_front();
				if (got.read_value !== want.read_value)
					report("read_value", want.read_value, got.read_value);
				if (got.count !== want.count)
					report("count", 32'(want.count), 32'(got.count));
				if (got.status !== want.status)
					report("status", 32'(want.status), 32'(got.status));
			end
		endtask
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cmd_valid = 1'b0;
	logic  cmd_ready;
	cmd_t  cmd = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	int send_idle = 0;
	int recv_stall = 0;
	int quiet_cycles = 0;
	bit growing = 1'b1;
	list_tracker tracker = new();

	indexed_list_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// result side: check on handshake, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_response(rsp);
		rsp_ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n && !(cmd_valid && cmd_ready) && !(rsp_valid && rsp_ready))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_command(input logic [2:0] code, input logic signed [31:0] v,
			input logic [4:0] p);
		cmd_t c;
		c.command  = code;
		c.value    = v;
		c.position = p;
		if ($urandom_range(99) < send_idle) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		tracker.take_command(c);
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (tracker.expected_rsps.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// mostly legal commands, steered so the list swings between empty and full
	task automatic random_command();
		int n;
		int roll;
		int sub;
		logic [2:0] code;
		logic [4:0] p;
		logic signed [31:0] v;
		n = tracker.cells.size();
		if (n >= DEPTH)
			growing = 1'b0;
		else if (n == 0)
			growing = 1'b1;
		sub = $urandom_range(2);
		roll = $urandom_range(99);
		if (roll < 8) begin
			code = 3'($urandom_range(7));
			p = 5'($urandom_range(31));
		end else begin
			roll = $urandom_range(99);
			if (roll < 20) begin
				code = CMD_READ;
				p = (n > 0) ? 5'($urandom_range(n - 1)) : 5'd0;
			end else if (roll < 20 + (growing ? 55 : 25)) begin
				case (sub)
				0: code = CMD_INS_HEAD;
				1: code = CMD_INS_TAIL;
				default: code = CMD_INS_AT;
				endcase
				p = 5'($urandom_range(n));
			end else begin
				case (sub)
				0: code = CMD_DEL_HEAD;
				1: code = CMD_DEL_TAIL;
				default: code = CMD_DEL_AT;
				endcase
				p = (n > 0) ? 5'($urandom_range(n - 1)) : 5'd0;
			end
		end
		case ($urandom_range(9))
		0: v = 32'sh8000_0000;
		1: v = 32'sh7fff_ffff;
		2: v = -32'sd1;
		3: v = 32'sd0;
		default: v = $urandom;
		endcase
		send_command(code, v, p);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners
		send_command(CMD_READ, 32'sd0, 5'd0);
		send_command(CMD_DEL_HEAD, 32'sd0, 5'd0);
		send_command(CMD_DEL_TAIL, 32'sd0, 5'd0);
		send_command(CMD_DEL_AT, 32'sd0, 5'd0);
		send_command(CMD_INS_AT, 32'sd5, 5'd1);
		// position equal to count appends
		send_command(CMD_INS_AT, 32'sh8000_0000, 5'd0);
		send_command(CMD_INS_HEAD, 32'sh7fff_ffff, 5'd31);
		send_command(CMD_INS_TAIL, -32'sd1, 5'd0);
		send_command(CMD_INS_AT, 32'sh5a5a_a5a5, 5'd1);
		send_command(CMD_INS_AT, 32'sh1234_5678, 5'd4);
		send_command(CMD_INS_AT, 32'sd9, 5'd6);
		for (int i = 0; i < 5; i++)
			send_command(CMD_READ, 32'sd0, i[4:0]);
		send_command(CMD_READ, 32'sd0, 5'd16);
		send_command(CMD_READ, 32'sd0, 5'd31);
		send_command(CMD_DEL_AT, 32'sd0, 5'd5);
		send_command(CMD_DEL_AT, 32'sd0, 5'd1);
		send_command(CMD_UNUSED, 32'sh7fff_ffff, 5'd31);
		send_command(CMD_DEL_HEAD, 32'sd0, 5'd0);
		send_command(CMD_DEL_TAIL, 32'sd0, 5'd0);
		send_command(CMD_READ, 32'sd0, 5'd0);
		drain_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 71; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 71; end
			default: begin send_idle = 18; recv_stall = 18; end
			endcase
			repeat (ITEMS_PER_PHASE) random_command();
			drain_results();
		end

		while (tracker.expected_rsps.size() != 0) begin
			void'(tracker.expected_rsps.pop_front());
			tracker.report("missing result", '0, '0);
		end
		$display("ran %0d commands through directed corners and four idle/stall phases",
			tracker.commands);
		$display("responses by status: ok %0d, bad position %0d, empty %0d, full %0d",
			tracker.status_seen[ST_OK], tracker.status_seen[ST_BAD],
			tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_FULL]);
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
